// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHK_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication, disabled while reset is high.
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

// Next-cycle implication that also holds through reset.
`define CHK_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// File: hdl/x86alu_pkg.sv
// Types and constants of the 8086-style ALU with flags.
package x86alu_pkg;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_OR   = 4'd1,
    OP_ADC  = 4'd2,
    OP_SBB  = 4'd3,
    OP_AND  = 4'd4,
    OP_SUB  = 4'd5,
    OP_XOR  = 4'd6,
    OP_CMP  = 4'd7,
    OP_MOV  = 4'd8,
    OP_TEST = 4'd9
  } op_t;

  localparam logic [15:0] FLAG_MASK = 16'h08D5;
  localparam logic [15:0] HIGH_MASK = 16'hFF00;
  localparam logic [15:0] LOW_MASK  = 16'h00FF;

  localparam int CF_BIT = 0;
  localparam int PF_BIT = 2;
  localparam int AF_BIT = 4;
  localparam int ZF_BIT = 6;
  localparam int SF_BIT = 7;
  localparam int OF_BIT = 11;

  typedef struct packed {
    logic [3:0]  opcode;
    logic        wide;
    logic [15:0] source_value;
    logic [15:0] dest_value;
    logic [15:0] flags_in;
  } alu_in_t;

  typedef struct packed {
    logic [15:0] result_value;
    logic [15:0] flags_out;
  } alu_out_t;

endpackage

// File: hdl/x86alu_core.sv
// Combinational ALU datapath: result value and updated flags for one item.
module x86alu_core (
  input  x86alu_pkg::alu_in_t  item,
  output x86alu_pkg::alu_out_t res
);
  import x86alu_pkg::*;

  logic [15:0] wmask;
  logic [15:0] s;
  logic [15:0] d;
  logic        cin;
  logic [16:0] sum;
  logic [16:0] diff;
  logic [15:0] r;
  logic [15:0] stored;
  logic        carry;
  logic        ovf;
  logic        aux;
  logic        arith;
  logic        logical;
  logic        setflags;
  logic        sign;
  logic [15:0] nf;

  always_comb begin
    wmask = item.wide ? (HIGH_MASK | LOW_MASK) : LOW_MASK;
    s     = item.source_value & wmask;
    d     = item.dest_value & wmask;
    cin   = item.flags_in[CF_BIT];
    sum   = {1'b0, d} + {1'b0, s} + {16'd0, (item.opcode == OP_ADC) && cin};
    diff  = {1'b0, d} - {1'b0, s} - {16'd0, (item.opcode == OP_SBB) && cin};

    r        = d;
    stored   = d;
    carry    = 1'b0;
    ovf      = 1'b0;
    arith    = 1'b0;
    logical  = 1'b0;
    case (item.opcode) inside
      OP_ADD, OP_ADC: begin
        r      = sum[15:0] & wmask;
        stored = r;
        carry  = item.wide ? sum[16] : sum[8];
        ovf    = item.wide ? (~(d[15] ^ s[15]) & (d[15] ^ r[15]))
                           : (~(d[7] ^ s[7]) & (d[7] ^ r[7]));
        arith  = 1'b1;
      end
      OP_SBB, OP_SUB, OP_CMP: begin
        r      = diff[15:0] & wmask;
        stored = (item.opcode == OP_CMP) ? d : r;
        carry  = item.wide ? diff[16] : diff[8];
        ovf    = item.wide ? ((d[15] ^ s[15]) & (d[15] ^ r[15]))
                           : ((d[7] ^ s[7]) & (d[7] ^ r[7]));
        arith  = 1'b1;
      end
      OP_OR: begin
        r       = d | s;
        stored  = r;
        logical = 1'b1;
      end
      OP_AND: begin
        r       = d & s;
        stored  = r;
        logical = 1'b1;
      end
      OP_XOR: begin
        r       = d ^ s;
        stored  = r;
        logical = 1'b1;
      end
      OP_TEST: begin
        r       = d & s;
        stored  = d;
        logical = 1'b1;
      end
      OP_MOV: begin
        r      = s;
        stored = s;
      end
      default: begin
        r      = d;
        stored = d;
      end
    endcase

    setflags = arith | logical;
    aux      = arith & (d[4] ^ s[4] ^ r[4]);
    sign     = item.wide ? r[15] : r[7];

    nf         = 16'd0;
    nf[CF_BIT] = carry;
    nf[PF_BIT] = ~^r[7:0];
    nf[AF_BIT] = aux;
    nf[ZF_BIT] = (r == 16'd0);
    nf[SF_BIT] = sign;
    nf[OF_BIT] = ovf;

    res.result_value = stored;
    res.flags_out    = setflags ? ((item.flags_in & ~FLAG_MASK) | (nf & FLAG_MASK))
                                : item.flags_in;
  end

endmodule

// File: hdl/x86_alu_with_flags.sv
// Top level of the 8086-style two-operand ALU with flags.
// Each accepted item runs one operation (add, or, adc, sbb, and, sub, xor, cmp,
// mov or test) on 8-bit or 16-bit operands and returns the new destination
// value and the flags word, in which only carry, parity, auxiliary, zero, sign
// and overflow are replaced. An item is captured in an input register, passes
// through the ALU logic and lands in a result register, from which it is
// offered on the result port. A new item can be accepted every cycle while
// the result register is empty or its result is being taken. While a result
// waits to be taken, the block accepts one more item into its input register
// and then holds op_ready low. Other opcodes leave value and flags unchanged.
module x86_alu_with_flags (
  input  logic        clk,
  input  logic        rst,
  input  logic        op_valid,
  output logic        op_ready,
  input  logic [3:0]  opcode,
  input  logic        wide,
  input  logic [15:0] source_value,
  input  logic [15:0] dest_value,
  input  logic [15:0] flags_in,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [15:0] result_value,
  output logic [15:0] flags_out
);
  import x86alu_pkg::*;

  alu_in_t  stage;
  logic     stage_valid;
  alu_out_t alu_res;
  alu_out_t result;
  logic     out_free;

  assign out_free = !res_valid || res_ready;
  assign op_ready = !stage_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (op_ready) begin
      stage_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op_ready && op_valid) begin
      stage <= '{opcode: opcode, wide: wide, source_value: source_value,
                 dest_value: dest_value, flags_in: flags_in};
    end
  end

  x86alu_core u_core (
    .item (stage),
    .res  (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && stage_valid) begin
      result <= alu_res;
    end
  end

  assign result_value = result.result_value;
  assign flags_out    = result.flags_out;

endmodule

// File: hdl/x86alu_checker.sv
// Port-level checks of the ALU handshake and pipeline, bound to the top level.
`include "assert_macros.svh"

module x86alu_checker (
  input logic        clk,
  input logic        rst,
  input logic        op_valid,
  input logic        op_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [15:0] result_value,
  input logic [15:0] flags_out
);

  `CHK_NEXT_ALWAYS(a_reset_empties, clk, rst, !res_valid)
  `CHK_IMPLY(a_empty_takes_item, clk, rst, !res_valid, op_ready)
  `CHK_NEXT(a_item_reaches_output, clk, rst, (op_valid && op_ready) ##1 res_ready, res_valid)
  `CHK_NEXT(a_stall_holds, clk, rst, res_valid && !res_ready,
            res_valid && $stable(result_value) && $stable(flags_out))

endmodule

bind x86_alu_with_flags x86alu_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .op_valid     (op_valid),
  .op_ready     (op_ready),
  .res_valid    (res_valid),
  .res_ready    (res_ready),
  .result_value (result_value),
  .flags_out    (flags_out)
);

// File: test/x86_alu_with_flags_tb.sv
// Self-checking testbench of the 8086-style ALU with flags, with random idling on both channels.
`timescale 1ns / 100ps

module x86_alu_with_flags_tb;
  import x86alu_pkg::*;

  localparam logic [3:0] OP_UNDEF_LO = 4'd10;
  localparam logic [3:0] OP_UNDEF_HI = 4'd15;
  localparam logic [15:0] CORNER_VALUES [0:7] = '{
    16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h00FF, 16'h007F, 16'h0080, 16'h0001
  };

  logic        clk;
  logic        rst;
  logic        op_valid;
  logic        op_ready;
  logic [3:0]  opcode;
  logic        wide;
  logic [15:0] source_value;
  logic [15:0] dest_value;
  logic [15:0] flags_in;
  logic        res_valid;
  logic        res_ready;
  logic [15:0] result_value;
  logic [15:0] flags_out;

  alu_out_t pending_results [$];
  int       fail_count = 0;
  bit       tx_gaps = 1'b1;
  bit       rx_free = 1'b0;
  int       rx_hold = 0;

  x86_alu_with_flags u_top (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (op_valid),
    .op_ready     (op_ready),
    .opcode       (opcode),
    .wide         (wide),
    .source_value (source_value),
    .dest_value   (dest_value),
    .flags_in     (flags_in),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .result_value (result_value),
    .flags_out    (flags_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("x86_alu_with_flags regression: fail");
    $finish;
  end

  function automatic alu_out_t alu_predict(alu_in_t it);
    alu_out_t    res;
    logic [15:0] wmask;
    logic [15:0] sbit;
    logic [15:0] s;
    logic [15:0] d;
    logic [15:0] r;
    logic [15:0] nf;
    logic [16:0] full;
    logic        c;
    logic        store;
    logic        setf;
    wmask = it.wide ? 16'hFFFF : LOW_MASK;
    sbit  = it.wide ? 16'h8000 : 16'h0080;
    s     = it.source_value & wmask;
    d     = it.dest_value & wmask;
    r     = d;
    nf    = '0;
    store = 1'b1;
    setf  = 1'b1;
    case (it.opcode)
      OP_ADD, OP_ADC: begin
        c = (it.opcode == OP_ADC) ? it.flags_in[CF_BIT] : 1'b0;
        full = {1'b0, d} + {1'b0, s} + {16'd0, c};
        r = full[15:0] & wmask;
        nf[CF_BIT] = it.wide ? full[16] : full[8];
        nf[OF_BIT] = |(~(d ^ s) & (d ^ r) & sbit);
        nf[AF_BIT] = d[4] ^ s[4] ^ r[4];
      end
      OP_SBB, OP_SUB, OP_CMP: begin
        c = (it.opcode == OP_SBB) ? it.flags_in[CF_BIT] : 1'b0;
        r = (d - s - {15'd0, c}) & wmask;
        nf[CF_BIT] = {1'b0, d} < ({1'b0, s} + {16'd0, c});
        nf[OF_BIT] = |((d ^ s) & (d ^ r) & sbit);
        nf[AF_BIT] = d[4] ^ s[4] ^ r[4];
        if (it.opcode == OP_CMP) store = 1'b0;
      end
      OP_OR:  r = d | s;
      OP_AND: r = d & s;
      OP_XOR: r = d ^ s;
      OP_TEST: begin
        r = d & s;
        store = 1'b0;
      end
      OP_MOV: begin
        r = s;
        setf = 1'b0;
      end
      default: begin
        r = d;
        setf = 1'b0;
      end
    endcase
    res.flags_out = it.flags_in;
    if (setf) begin
      nf[ZF_BIT] = (r == 16'd0);
      nf[SF_BIT] = |(r & sbit);
      nf[PF_BIT] = ~^r[7:0];
      res.flags_out = (it.flags_in & ~FLAG_MASK) | (nf & FLAG_MASK);
    end
    res.result_value = (store ? r : d) & wmask;
    return res;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_operand();
    if ($urandom_range(0, 3) == 0) return CORNER_VALUES[3'($urandom_range(0, 7))];
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic alu_in_t random_item();
    alu_in_t it;
    if ($urandom_range(0, 19) == 0) it.opcode = 4'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
    else it.opcode = 4'($urandom_range(OP_ADD, OP_TEST));
    it.wide         = 1'($urandom_range(0, 1));
    it.source_value = pick_operand();
    it.dest_value   = pick_operand();
    it.flags_in     = 16'($urandom_range(0, 16'hFFFF));
    return it;
  endfunction

  task automatic send_item(alu_in_t it);
    int gap;
    gap = tx_gaps ? gap_len() : 0;
    if (gap > 0) begin
      op_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op_valid     <= 1'b1;
    opcode       <= it.opcode;
    wide         <= it.wide;
    source_value <= it.source_value;
    dest_value   <= it.dest_value;
    flags_in     <= it.flags_in;
    @(posedge clk);
    while (!op_ready) @(posedge clk);
    pending_results.push_back(alu_predict(it));
  endtask

  task automatic send_op(logic [3:0] op, logic w, logic [15:0] s, logic [15:0] d,
                         logic [15:0] f);
    alu_in_t it;
    it.opcode       = op;
    it.wide         = w;
    it.source_value = s;
    it.dest_value   = d;
    it.flags_in     = f;
    send_item(it);
  endtask

  task automatic wait_results_done();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_op(OP_ADD,  1'b0, 16'h0001, 16'h00FF, 16'h0000);
    send_op(OP_ADD,  1'b0, 16'hAB01, 16'hCD7F, 16'hFFFF);
    send_op(OP_ADD,  1'b1, 16'h0001, 16'hFFFF, 16'h0000);
    send_op(OP_ADD,  1'b1, 16'h0001, 16'h7FFF, 16'hF72A);
    send_op(OP_ADC,  1'b1, 16'h0000, 16'hFFFF, 16'h0001);
    send_op(OP_ADC,  1'b0, 16'h00FF, 16'h00FF, 16'hFFFF);
    send_op(OP_ADC,  1'b0, 16'h0010, 16'h0008, 16'h0000);
    send_op(OP_SBB,  1'b0, 16'h0000, 16'h0000, 16'h0001);
    send_op(OP_SBB,  1'b1, 16'hFFFF, 16'hFFFF, 16'h0001);
    send_op(OP_SUB,  1'b0, 16'h0001, 16'h0080, 16'h0000);
    send_op(OP_SUB,  1'b1, 16'h0001, 16'h8000, 16'hFFFF);
    send_op(OP_SUB,  1'b1, 16'h1234, 16'h1234, 16'h0000);
    send_op(OP_CMP,  1'b0, 16'h0055, 16'h1255, 16'h0000);
    send_op(OP_CMP,  1'b1, 16'h0001, 16'h0000, 16'hFFFF);
    send_op(OP_OR,   1'b0, 16'hFF00, 16'h00F0, 16'hFFFF);
    send_op(OP_OR,   1'b1, 16'h0000, 16'h0000, 16'h0000);
    send_op(OP_AND,  1'b1, 16'hFFFF, 16'h8001, 16'hFFFF);
    send_op(OP_XOR,  1'b0, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_op(OP_XOR,  1'b1, 16'hAAAA, 16'h5555, 16'hFFFF);
    send_op(OP_TEST, 1'b0, 16'h0080, 16'hFF80, 16'h0000);
    send_op(OP_TEST, 1'b1, 16'h0F0F, 16'hF0F0, 16'hFFFF);
    send_op(OP_MOV,  1'b0, 16'hBEEF, 16'h1234, 16'hFFFF);
    send_op(OP_MOV,  1'b1, 16'hBEEF, 16'h1234, 16'h0000);
    send_op(OP_UNDEF_LO, 1'b1, 16'hFFFF, 16'hC3A5, 16'h5A5A);
    send_op(OP_UNDEF_HI, 1'b0, 16'hFFFF, 16'hC3A5, 16'hFFFF);
  endtask

  task automatic test_random_mix(int count);
    repeat (count) send_item(random_item());
  endtask

  task automatic test_no_idle(int count);
    tx_gaps = 1'b0;
    rx_free = 1'b1;
    repeat (count) send_item(random_item());
    tx_gaps = 1'b1;
    rx_free = 1'b0;
  endtask

  task automatic test_backpressure(int count);
    tx_gaps = 1'b0;
    rx_hold = 60;
    repeat (count) send_item(random_item());
    tx_gaps = 1'b1;
  endtask

  task automatic test_drain_pause(int count);
    repeat (count) send_item(random_item());
    op_valid <= 1'b0;
    wait_results_done();
    repeat (count) send_item(random_item());
  endtask

  initial begin : rx_drive
    int wait_left;
    wait_left = 0;
    res_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        res_ready <= 1'b0;
      end else if (rx_hold > 0) begin
        res_ready <= 1'b0;
        rx_hold--;
      end else if (rx_free) begin
        res_ready <= 1'b1;
      end else if (wait_left > 0) begin
        res_ready <= 1'b0;
        wait_left--;
      end else begin
        res_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) wait_left = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    alu_out_t exp_res;
    if (!rst && res_valid && res_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no item waiting: result_value %h flags_out %h",
               result_value, flags_out);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (result_value !== exp_res.result_value) begin
          $error("result_value expected %h actual %h", exp_res.result_value, result_value);
          fail_count++;
        end
        if (flags_out !== exp_res.flags_out) begin
          $error("flags_out expected %h actual %h", exp_res.flags_out, flags_out);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst          = 1'b1;
    op_valid     = 1'b0;
    opcode       = OP_ADD;
    wide         = 1'b0;
    source_value = '0;
    dest_value   = '0;
    flags_in     = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_mix(350);
    test_backpressure(50);
    test_no_idle(80);
    test_drain_pause(20);
    test_backpressure(30);
    test_random_mix(80);
    op_valid <= 1'b0;
    wait_results_done();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("x86_alu_with_flags regression: pass");
    end else begin
      $display("x86_alu_with_flags regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/x86alu_pkg.sv
hdl/x86alu_core.sv
hdl/x86_alu_with_flags.sv
hdl/x86alu_checker.sv
test/x86_alu_with_flags_tb.sv
